// ===== src/spd_pkg.sv =====
// ----------------------------------------------------------------------------
// spd_pkg
// Shared constants for the shortest path distance block: field widths,
// operation codes and parameter defaults.
// ----------------------------------------------------------------------------
package spd_pkg;

    localparam int NODE_BITS      = 6;
    localparam int WEIGHT_IN_BITS = 16;
    localparam int DIST_BITS      = 22;
    localparam int OP_BITS        = 2;

    localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};

    localparam logic [OP_BITS-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_BITS-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_BITS-1:0] OP_QUERY  = 2'd2;

    localparam int DEF_MAX_NODES   = 64;
    localparam int DEF_WEIGHT_BITS = 16;

endpackage

// ===== src/spd_ram.sv =====
// ----------------------------------------------------------------------------
// spd_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module spd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/spd_ctrl.sv =====
// ----------------------------------------------------------------------------
// spd_ctrl
// Sequencer: edge updates, post-reset clearing of the edge store, and the
// array-scan Dijkstra search over the edge and distance memories.
// ----------------------------------------------------------------------------
module spd_ctrl
    import spd_pkg::*;
#(
    parameter int MAX_NODES   = DEF_MAX_NODES,
    parameter int WEIGHT_BITS = DEF_WEIGHT_BITS,
    parameter int NW          = $clog2(MAX_NODES),
    parameter int AW          = $clog2(MAX_NODES * MAX_NODES),
    parameter int DW          = (WEIGHT_BITS > DIST_BITS) ? WEIGHT_BITS : DIST_BITS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [OP_BITS-1:0]        i_operation,
    input  logic [NODE_BITS-1:0]      i_first_node,
    input  logic [NODE_BITS-1:0]      i_second_node,
    input  logic [WEIGHT_IN_BITS-1:0] i_edge_weight,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [DIST_BITS-1:0]      o_path_distance,
    output logic                      o_reachable,
    // edge store
    output logic                      o_e_we,
    output logic [AW-1:0]             o_e_waddr,
    output logic [WEIGHT_BITS:0]      o_e_wdata,
    output logic [AW-1:0]             o_e_raddr,
    input  logic [WEIGHT_BITS:0]      i_e_rdata,
    // distance store: {discovered, settled, distance}
    output logic                      o_d_we,
    output logic [NW-1:0]             o_d_waddr,
    output logic [DW+1:0]             o_d_wdata,
    output logic [NW-1:0]             o_d_raddr,
    input  logic [DW+1:0]             i_d_rdata
);

    localparam int CW = AW + 1;
    localparam int SW = DW + 1;

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_MIRROR = 3'd2;
    localparam logic [2:0] S_INIT   = 3'd3;
    localparam logic [2:0] S_FIND   = 3'd4;
    localparam logic [2:0] S_SETTLE = 3'd5;
    localparam logic [2:0] S_RELAX  = 3'd6;
    localparam logic [2:0] S_RESULT = 3'd7;

    logic [2:0]             r_state, n_state;
    logic [CW-1:0]          r_cnt, n_cnt;
    logic                   r_pv, n_pv;
    logic [NW-1:0]          r_pidx, n_pidx;
    logic [NW-1:0]          r_a, n_a;
    logic [NW-1:0]          r_b, n_b;
    logic [WEIGHT_BITS:0]   r_ew, n_ew;
    logic [AW-1:0]          r_base, n_base;
    logic                   r_found, n_found;
    logic [NW-1:0]          r_best, n_best;
    logic [DW-1:0]          r_bestd, n_bestd;
    logic [DIST_BITS-1:0]   r_rdist, n_rdist;
    logic                   r_rreach, n_rreach;
    logic                   r_ovld, n_ovld;
    logic [DIST_BITS-1:0]   r_odist, n_odist;
    logic                   r_oreach, n_oreach;

    logic                   a_bad, b_bad;
    logic [NW-1:0]          in_a, in_b;
    logic [WEIGHT_BITS-1:0] in_w;
    logic                   scan_end;
    logic                   d_disc, d_set;
    logic [DW-1:0]          d_dist;
    logic [DW-1:0]          e_len;
    logic [SW-1:0]          sum;
    logic [DW-1:0]          relaxed;

    assign a_bad   = 32'(i_first_node) >= 32'(MAX_NODES);
    assign b_bad   = 32'(i_second_node) >= 32'(MAX_NODES);
    assign in_a    = NW'(i_first_node);
    assign in_b    = NW'(i_second_node);
    assign in_w    = WEIGHT_BITS'(i_edge_weight);
    assign scan_end = (r_cnt == CW'(MAX_NODES)) && !r_pv;

    assign d_disc  = i_d_rdata[DW+1];
    assign d_set   = i_d_rdata[DW];
    assign d_dist  = i_d_rdata[DW-1:0];
    assign e_len   = DW'(i_e_rdata[WEIGHT_BITS-1:0]);
    assign sum     = SW'(r_bestd) + SW'(e_len);
    assign relaxed = (sum > SW'(DIST_MAX)) ? DW'(DIST_MAX) : sum[DW-1:0];

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_pv     = 1'b0;
        n_pidx   = r_cnt[NW-1:0];
        n_a      = r_a;
        n_b      = r_b;
        n_ew     = r_ew;
        n_base   = r_base;
        n_found  = r_found;
        n_best   = r_best;
        n_bestd  = r_bestd;
        n_rdist  = r_rdist;
        n_rreach = r_rreach;
        n_ovld   = r_ovld && !i_ready;
        n_odist  = r_odist;
        n_oreach = r_oreach;

        o_e_we    = 1'b0;
        o_e_waddr = r_cnt[AW-1:0];
        o_e_wdata = '0;
        o_e_raddr = r_base + AW'(r_cnt[NW-1:0]);
        o_d_we    = 1'b0;
        o_d_waddr = r_pidx;
        o_d_wdata = '0;
        o_d_raddr = r_cnt[NW-1:0];

        case (r_state)
            S_CLEAR: begin
                o_e_we = 1'b1;
                n_cnt  = r_cnt + CW'(1);
                if (r_cnt == CW'(MAX_NODES * MAX_NODES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_a     = in_a;
                    n_b     = in_b;
                    n_cnt   = '0;
                    n_found = 1'b0;
                    if (i_operation == OP_QUERY) begin
                        n_base = AW'(AW'(in_a) * AW'(MAX_NODES));
                        if (a_bad || b_bad) begin
                            n_rdist  = '0;
                            n_rreach = 1'b0;
                            n_state  = S_RESULT;
                        end else if (in_a == in_b) begin
                            n_rdist  = '0;
                            n_rreach = 1'b1;
                            n_state  = S_RESULT;
                        end else begin
                            n_state = S_INIT;
                        end
                    end else if ((i_operation == OP_INSERT || i_operation == OP_REMOVE)
                                 && !a_bad && !b_bad) begin
                        n_ew      = {i_operation == OP_INSERT, in_w};
                        o_e_we    = 1'b1;
                        o_e_waddr = AW'(AW'(in_a) * AW'(MAX_NODES)) + AW'(in_b);
                        o_e_wdata = {i_operation == OP_INSERT, in_w};
                        n_state   = S_MIRROR;
                    end
                end
            end
            S_MIRROR: begin
                o_e_we    = 1'b1;
                o_e_waddr = AW'(AW'(r_b) * AW'(MAX_NODES)) + AW'(r_a);
                o_e_wdata = r_ew;
                n_state   = S_IDLE;
            end
            S_INIT: begin
                if (r_cnt != CW'(MAX_NODES)) begin
                    n_pv  = 1'b1;
                    n_cnt = r_cnt + CW'(1);
                end
                if (r_pv) begin
                    o_d_we    = 1'b1;
                    o_d_wdata = {i_e_rdata[WEIGHT_BITS] && (r_pidx != r_a),
                                 r_pidx == r_a, e_len};
                end
                if (scan_end) begin
                    n_cnt   = '0;
                    n_found = 1'b0;
                    n_state = S_FIND;
                end
            end
            S_FIND: begin
                if (r_cnt != CW'(MAX_NODES)) begin
                    n_pv  = 1'b1;
                    n_cnt = r_cnt + CW'(1);
                end
                if (r_pv && d_disc && !d_set && (!r_found || d_dist < r_bestd)) begin
                    n_found = 1'b1;
                    n_best  = r_pidx;
                    n_bestd = d_dist;
                end
                if (scan_end) begin
                    if (r_found) begin
                        n_state = S_SETTLE;
                    end else begin
                        n_rdist  = '0;
                        n_rreach = 1'b0;
                        n_state  = S_RESULT;
                    end
                end
            end
            S_SETTLE: begin
                o_d_we    = 1'b1;
                o_d_waddr = r_best;
                o_d_wdata = {1'b1, 1'b1, r_bestd};
                n_cnt     = '0;
                n_base    = AW'(AW'(r_best) * AW'(MAX_NODES));
                if (r_best == r_b) begin
                    n_rdist  = r_bestd[DIST_BITS-1:0];
                    n_rreach = 1'b1;
                    n_state  = S_RESULT;
                end else begin
                    n_state = S_RELAX;
                end
            end
            S_RELAX: begin
                if (r_cnt != CW'(MAX_NODES)) begin
                    n_pv  = 1'b1;
                    n_cnt = r_cnt + CW'(1);
                end
                if (r_pv && i_e_rdata[WEIGHT_BITS] && !d_set
                    && (!d_disc || relaxed < d_dist)) begin
                    o_d_we    = 1'b1;
                    o_d_wdata = {1'b1, 1'b0, relaxed};
                end
                if (scan_end) begin
                    n_cnt   = '0;
                    n_found = 1'b0;
                    n_state = S_FIND;
                end
            end
            S_RESULT: begin
                if (!r_ovld || i_ready) begin
                    n_ovld   = 1'b1;
                    n_odist  = r_rdist;
                    n_oreach = r_rreach;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_cnt   <= '0;
            r_pv    <= 1'b0;
            r_found <= 1'b0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_pv    <= n_pv;
            r_found <= n_found;
            r_ovld  <= n_ovld;
        end
        r_pidx   <= n_pidx;
        r_a      <= n_a;
        r_b      <= n_b;
        r_ew     <= n_ew;
        r_base   <= n_base;
        r_best   <= n_best;
        r_bestd  <= n_bestd;
        r_rdist  <= n_rdist;
        r_rreach <= n_rreach;
        r_odist  <= n_odist;
        r_oreach <= n_oreach;
    end

    assign o_ready         = (r_state == S_IDLE);
    assign o_valid         = r_ovld;
    assign o_path_distance = r_odist;
    assign o_reachable     = r_oreach;

endmodule

// ===== src/shortest_path_distance.sv =====
// ----------------------------------------------------------------------------
// shortest_path_distance
// Undirected weighted graph store with single-pair Dijkstra distance query.
//
//   channel   direction  handshake          word
//   input     in         i_valid/o_ready    operation, nodes, edge weight
//   output    out        o_valid/i_ready    path distance, reachable
//
// Insert and remove write the edge memory once per direction.
// A query scans the source row into the distance memory, then alternates a
// scan for the nearest unsettled node with a relax scan of that node's edge row.
// After reset a clearing pass over all MAX_NODES^2 entries empties the edge memory.
// One item at a time; a result waits in the output register while the next
// item is taken, and a query holds at its end while that register is full.
// ----------------------------------------------------------------------------
module shortest_path_distance
    import spd_pkg::*;
#(
    parameter int MAX_NODES   = DEF_MAX_NODES,
    parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [OP_BITS-1:0]        i_operation,
    input  logic [NODE_BITS-1:0]      i_first_node,
    input  logic [NODE_BITS-1:0]      i_second_node,
    input  logic [WEIGHT_IN_BITS-1:0] i_edge_weight,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [DIST_BITS-1:0]      o_path_distance,
    output logic                      o_reachable
);

    localparam int NW = $clog2(MAX_NODES);
    localparam int AW = $clog2(MAX_NODES * MAX_NODES);
    localparam int DW = (WEIGHT_BITS > DIST_BITS) ? WEIGHT_BITS : DIST_BITS;

    logic                 e_we;
    logic [AW-1:0]        e_waddr, e_raddr;
    logic [WEIGHT_BITS:0] e_wdata, e_rdata;
    logic                 d_we;
    logic [NW-1:0]        d_waddr, d_raddr;
    logic [DW+1:0]        d_wdata, d_rdata;

    spd_ctrl #(
        .MAX_NODES  (MAX_NODES),
        .WEIGHT_BITS(WEIGHT_BITS),
        .NW         (NW),
        .AW         (AW),
        .DW         (DW)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_operation    (i_operation),
        .i_first_node   (i_first_node),
        .i_second_node  (i_second_node),
        .i_edge_weight  (i_edge_weight),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_path_distance(o_path_distance),
        .o_reachable    (o_reachable),
        .o_e_we         (e_we),
        .o_e_waddr      (e_waddr),
        .o_e_wdata      (e_wdata),
        .o_e_raddr      (e_raddr),
        .i_e_rdata      (e_rdata),
        .o_d_we         (d_we),
        .o_d_waddr      (d_waddr),
        .o_d_wdata      (d_wdata),
        .o_d_raddr      (d_raddr),
        .i_d_rdata      (d_rdata)
    );

    spd_ram #(
        .WIDTH(WEIGHT_BITS + 1),
        .DEPTH(MAX_NODES * MAX_NODES)
    ) u_edge_ram (
        .i_clk  (i_clk),
        .i_we   (e_we),
        .i_waddr(e_waddr),
        .i_wdata(e_wdata),
        .i_raddr(e_raddr),
        .o_rdata(e_rdata)
    );

    spd_ram #(
        .WIDTH(DW + 2),
        .DEPTH(MAX_NODES)
    ) u_dist_ram (
        .i_clk  (i_clk),
        .i_we   (d_we),
        .i_waddr(d_waddr),
        .i_wdata(d_wdata),
        .i_raddr(d_raddr),
        .o_rdata(d_rdata)
    );

endmodule

// ===== src/spd_chk.sv =====
// ----------------------------------------------------------------------------
// spd_chk
// Port-level checks for the shortest path distance block.
// ----------------------------------------------------------------------------
module spd_chk
    import spd_pkg::*;
#(
    parameter int MAX_NODES = DEF_MAX_NODES
) (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_valid,
    input logic                      o_ready,
    input logic [OP_BITS-1:0]        i_operation,
    input logic [NODE_BITS-1:0]      i_first_node,
    input logic [NODE_BITS-1:0]      i_second_node,
    input logic                      o_valid,
    input logic                      i_ready,
    input logic [DIST_BITS-1:0]      o_path_distance,
    input logic                      o_reachable
);

    logic self_query;

    assign self_query = i_valid && o_ready && (i_operation == OP_QUERY)
                        && (i_first_node == i_second_node)
                        && (32'(i_first_node) < 32'(MAX_NODES)) && !o_valid;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_path_distance) && $stable(o_reachable))
        else $error("result word changed while stalled");

    a_unreach_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_reachable |-> o_path_distance == '0)
        else $error("unreachable result with nonzero distance");

    a_self: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        self_query |-> ##2 (o_valid && o_reachable && o_path_distance == '0))
        else $error("self query did not return zero distance");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_ready)
        else $error("block active right after reset");

    a_no_edge_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_operation != OP_QUERY && !o_valid |=> !o_valid)
        else $error("result after edge update");

endmodule

bind shortest_path_distance spd_chk #(.MAX_NODES(MAX_NODES)) u_spd_chk (.*);

// ===== dv/shortest_path_distance_test.sv =====
// ----------------------------------------------------------------------------
// shortest_path_distance_test
// Drives insert, remove, query and unused-code words into the graph block and compares each
// query result against an in-bench Dijkstra over a mirrored adjacency store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module shortest_path_distance_test;
    import spd_pkg::*;

    localparam int NODES = DEF_MAX_NODES;
    localparam int WANT_DEPTH = 256;
    localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [DIST_BITS-1:0] distance;
        logic                 reachable;
    } t_route;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_valid;
    logic                      o_ready;
    logic [OP_BITS-1:0]        i_operation;
    logic [NODE_BITS-1:0]      i_first_node;
    logic [NODE_BITS-1:0]      i_second_node;
    logic [WEIGHT_IN_BITS-1:0] i_edge_weight;
    logic                      o_valid;
    logic                      i_ready;
    logic [DIST_BITS-1:0]      o_path_distance;
    logic                      o_reachable;

    bit                        link_on [NODES][NODES];
    logic [WEIGHT_IN_BITS-1:0] link_len [NODES][NODES];
    t_route                    want_q [WANT_DEPTH];
    int                        want_wr;
    int                        want_rd;

    int  mismatches;
    int  routes_seen;
    int  words_sent;
    bit  calm;
    bit  hold_off;

    shortest_path_distance u_dut (.*);

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic t_route shortest_route(int src, int dst);
        t_route                r;
        bit                    done [NODES];
        bit                    seen [NODES];
        logic [DIST_BITS-1:0]  span [NODES];
        logic [DIST_BITS:0]    sum;
        int                    best;
        r = '0;
        if (src == dst) begin
            r.reachable = 1'b1;
            return r;
        end
        for (int i = 0; i < NODES; i++) begin
            done[i] = 0;
            seen[i] = 0;
            span[i] = '0;
        end
        done[src] = 1;
        seen[src] = 1;
        for (int i = 0; i < NODES; i++) begin
            if (link_on[src][i] && i != src) begin
                seen[i] = 1;
                span[i] = DIST_BITS'(link_len[src][i]);
            end
        end
        forever begin
            best = -1;
            for (int i = 0; i < NODES; i++) begin
                if (seen[i] && !done[i] && (best < 0 || span[i] < span[best])) best = i;
            end
            if (best < 0) return r;
            done[best] = 1;
            if (best == dst) begin
                r.distance  = span[best];
                r.reachable = 1'b1;
                return r;
            end
            for (int i = 0; i < NODES; i++) begin
                if (link_on[best][i] && !done[i]) begin
                    sum = (DIST_BITS+1)'(span[best]) + (DIST_BITS+1)'(link_len[best][i]);
                    if (sum > {1'b0, DIST_MAX}) sum = {1'b0, DIST_MAX};
                    if (!seen[i] || sum[DIST_BITS-1:0] < span[i]) begin
                        seen[i] = 1;
                        span[i] = sum[DIST_BITS-1:0];
                    end
                end
            end
        end
    endfunction

    task automatic send_word(logic [OP_BITS-1:0] op, int a, int b, int w);
        while (!calm && $urandom_range(99) < 27) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_operation   <= op;
        i_first_node  <= NODE_BITS'(a);
        i_second_node <= NODE_BITS'(b);
        i_edge_weight <= WEIGHT_IN_BITS'(w);
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        words_sent++;
        case (op)
            OP_INSERT: begin
                link_on[a][b] = 1; link_len[a][b] = WEIGHT_IN_BITS'(w);
                link_on[b][a] = 1; link_len[b][a] = WEIGHT_IN_BITS'(w);
            end
            OP_REMOVE: begin
                link_on[a][b] = 0;
                link_on[b][a] = 0;
            end
            OP_QUERY: begin
                want_q[want_wr] = shortest_route(a, b);
                want_wr++;
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        t_route want;
        if (i_rst_n && o_valid && i_ready) begin
            routes_seen++;
            if (want_rd == want_wr) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %0d/%0b",
                    o_path_distance, o_reachable);
            end else begin
                want = want_q[want_rd];
                want_rd++;
                if (want.distance !== o_path_distance || want.reachable !== o_reachable) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %0d/%0b got %0d/%0b", want.distance,
                            want.reachable, o_path_distance, o_reachable);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || hold_off) i_ready <= 1'b0;
        else if (calm) i_ready <= 1'b1;
        else i_ready <= ($urandom_range(99) >= 27);
    end

    task automatic test_directed();
        send_word(OP_QUERY, 0, 63, 0);
        send_word(OP_QUERY, 5, 5, 0);
        send_word(OP_INSERT, 0, 63, 16'hffff);
        send_word(OP_QUERY, 63, 0, 0);
        send_word(OP_INSERT, 0, 1, 0);
        send_word(OP_INSERT, 1, 63, 3);
        send_word(OP_QUERY, 0, 63, 0);
        send_word(OP_INSERT, 7, 7, 9);
        send_word(OP_QUERY, 7, 0, 0);
        send_word(OP_REMOVE, 1, 63, 0);
        send_word(OP_REMOVE, 20, 30, 0);
        send_word(OP_UNUSED, 42, 21, 16'h5555);
        send_word(OP_QUERY, 0, 63, 0);
        send_word(OP_INSERT, 42, 21, 16'haaaa);
        send_word(OP_INSERT, 21, 63, 16'h5555);
        send_word(OP_QUERY, 42, 0, 0);
        send_word(OP_QUERY, 62, 1, 16'hffff);
    endtask

    task automatic test_long_chain();
        for (int i = 0; i < NODES - 1; i++) send_word(OP_INSERT, i, i + 1, 16'hffff);
        send_word(OP_QUERY, 0, 63, 0);
        send_word(OP_QUERY, 63, 2, 0);
    endtask

    task automatic test_random();
        int op, a, b;
        for (int n = 0; n < 56; n++) begin
            op = $urandom_range(99);
            a  = $urandom_range(n < 28 ? 15 : 63);
            b  = $urandom_range(n < 28 ? 15 : 63);
            if (n == 20) calm = 1;
            if (n == 45) calm = 0;
            if (op < 50) send_word(OP_INSERT, a, b, $urandom_range(65535));
            else if (op < 65) send_word(OP_REMOVE, a, b, $urandom_range(65535));
            else if (op < 97) send_word(OP_QUERY, a, b, $urandom_range(65535));
            else send_word(OP_UNUSED, a, b, $urandom_range(65535));
        end
    endtask

    task automatic test_backpressure();
        fork
            begin
                hold_off = 1;
                repeat (40000) @(posedge i_clk);
                hold_off = 0;
            end
            for (int n = 0; n < 4; n++) send_word(OP_QUERY, n, 63 - n, 0);
        join
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_operation = OP_INSERT;
        i_first_node = '0;
        i_second_node = '0;
        i_edge_weight = '0;
        calm = 0;
        hold_off = 0;
        mismatches = 0;
        routes_seen = 0;
        words_sent = 0;
        want_wr = 0;
        want_rd = 0;
        for (int i = 0; i < NODES; i++)
            for (int j = 0; j < NODES; j++) link_on[i][j] = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_long_chain();
        test_backpressure();
        test_random();
        i_valid <= 1'b0;
        while (want_rd != want_wr) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        $display("sent %0d words, checked %0d query results", words_sent, routes_seen);
        $display("covered edge updates, removals, unused codes, long chains and stalls");
        if (mismatches == 0 && want_rd == want_wr)
            $display("shortest_path_distance_test OK");
        else
            $display("shortest_path_distance_test NOT OK");
        $finish;
    end

    initial begin
        #50ms;
        $display("shortest_path_distance_test NOT OK");
        $finish;
    end

endmodule
